@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/srr_pkg.sv @@
package srr_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int MAX_SEQ_BITS = 16;

    // Fixed field widths of the ports.
    localparam int SEQ_W     = 16;
    localparam int DATA_W    = 64;
    localparam int WS_W      = 6;
    localparam int SB_W      = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam int SPACE_W = MAX_SEQ_BITS + 1;
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int N_W     = $clog2(MAX_WINDOW + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BITS = 2'd1;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RESET   = 6'd4;
    localparam logic [SB_W-1:0] SEQUENCE_BITS_RESET = 5'd16;

    // Result kinds.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // One classified packet, as it waits between front and back.
    typedef struct packed {
        logic [SEQ_W-1:0]        seq;
        logic [PAYLOAD_BITS-1:0] data;
        logic [SEQ_W-1:0]        mask;
        logic [N_W-1:0]          n;
        logic                    drop;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

endpackage

@@ rtl/srr_if.sv @@
interface srr_pkt_if;
    import srr_pkg::*;
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  seq_num;
    logic              checksum_good;
    logic [DATA_W-1:0] payload;

    modport source (output valid, seq_num, checksum_good, payload, input ready);
    modport sink   (input valid, seq_num, checksum_good, payload, output ready);
endinterface

interface srr_res_if;
    import srr_pkg::*;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [DATA_W-1:0] delivered_data;
    logic              last_of_run;

    modport source (output valid, result_kind, ack_seq, delivered_data, last_of_run,
                    input ready);
    modport sink   (input valid, result_kind, ack_seq, delivered_data, last_of_run,
                    output ready);
endinterface

interface srr_cfg_if;
    import srr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/srr_ram.sv @@
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/srr_front.sv @@
module srr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    srr_pkt_if.sink              i_pkt,
    srr_cfg_if.sink              i_cfg,
    input  logic                 i_pop,
    output srr_pkg::t_queue_head o_head
);
    import srr_pkg::*;

    logic [WS_W-1:0]    r_window_size;
    logic [SB_W-1:0]    r_sequence_bits;
    t_entry             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic [SB_W-1:0]    w_sb;
    logic [WS_W-1:0]    w_ws;
    logic [SPACE_W-1:0] w_space;
    logic [SPACE_W-1:0] w_half;
    logic [SPACE_W-1:0] w_n_wide;
    logic [SEQ_W-1:0]   w_mask;
    t_entry             w_entry;
    logic               w_push;
    logic               w_pop;

    // Effective sequence space and window size from the registers, and the queue entry for the incoming packet.
    always_comb begin
        w_sb = (r_sequence_bits == '0 || r_sequence_bits > SB_W'(MAX_SEQ_BITS))
             ? SB_W'(MAX_SEQ_BITS) : r_sequence_bits;
        w_ws = (r_window_size == '0) ? WS_W'(1) : r_window_size;
        w_space = SPACE_W'(1) << w_sb;
        w_half  = w_space >> 1;
        w_mask  = SEQ_W'(w_space - SPACE_W'(1));
        w_n_wide = SPACE_W'(w_ws);
        if (w_n_wide > w_half) begin
            w_n_wide = w_half;
        end
        if (w_n_wide > SPACE_W'(MAX_WINDOW)) begin
            w_n_wide = SPACE_W'(MAX_WINDOW);
        end
        w_entry.seq  = i_pkt.seq_num;
        w_entry.data = i_pkt.payload[PAYLOAD_BITS-1:0];
        w_entry.mask = w_mask;
        w_entry.n    = N_W'(w_n_wide);
        w_entry.drop = !i_pkt.checksum_good || ((i_pkt.seq_num & ~w_mask) != '0);
    end

    assign i_pkt.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign i_cfg.ready = 1'b1;
    assign w_push      = i_pkt.valid && i_pkt.ready;
    assign w_pop       = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_entry;
        end
        if (!i_rst_n) begin
            r_window_size   <= WINDOW_SIZE_RESET;
            r_sequence_bits <= SEQUENCE_BITS_RESET;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.reg_index == REG_WINDOW_SIZE) begin
                r_window_size <= i_cfg.wr_data[WS_W-1:0];
            end
            if (i_cfg.valid && i_cfg.reg_index == REG_SEQUENCE_BITS) begin
                r_sequence_bits <= i_cfg.wr_data[SB_W-1:0];
            end
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_queue[r_rd_ptr];

endmodule

@@ rtl/srr_back.sv @@
module srr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srr_pkg::t_queue_head i_head,
    output logic                 o_pop,
    srr_res_if.source            o_res
);
    import srr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DATA, S_RUN} t_state;

    t_state                  r_state, n_state;
    t_entry                  r_item, n_item;
    logic [SEQ_W-1:0]        r_base, n_base;
    logic [MAX_WINDOW-1:0]   r_valid, n_valid;
    logic [N_W-1:0]          r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [SEQ_W-1:0]        r_out_ack, n_out_ack;
    logic [PAYLOAD_BITS-1:0] r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;

    logic                    w_free;
    logic                    w_done;
    logic [SEQ_W-1:0]        w_base_r;
    logic [SEQ_W-1:0]        w_dist;
    logic [SEQ_W-1:0]        w_back;
    logic                    w_in_win;
    logic                    w_in_prev;
    logic [SLOT_W-1:0]       w_slot;
    logic                    w_is_head;
    logic [SEQ_W-1:0]        w_next_base;
    logic [SLOT_W-1:0]       w_next_slot;
    logic [N_W-1:0]          w_after;
    logic                    w_cont;
    logic                    w_ram_we;
    logic                    w_ram_re;
    logic [PAYLOAD_BITS-1:0] w_rd_data;

    srr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_slot),
        .i_wr_data (r_item.data),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_next_slot),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_free      = !r_out_valid || o_res.ready;
        w_base_r    = r_base & r_item.mask;
        w_dist      = (r_item.seq - w_base_r) & r_item.mask;
        w_back      = (w_base_r - r_item.seq) & r_item.mask;
        w_in_win    = w_dist < SEQ_W'(r_item.n);
        w_in_prev   = (w_back != '0) && (w_back <= SEQ_W'(r_item.n));
        w_slot      = r_item.seq[SLOT_W-1:0];
        w_is_head   = !r_valid[w_slot] && (r_item.seq == w_base_r);
        w_next_base = (r_base + SEQ_W'(1)) & r_item.mask;
        w_next_slot = w_next_base[SLOT_W-1:0];
        w_after     = r_cnt + N_W'(1);
        w_cont      = (w_after < r_item.n) && r_valid[w_next_slot];

        n_state     = r_state;
        n_item      = r_item;
        n_base      = r_base;
        n_valid     = r_valid;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_ack   = r_out_ack;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        w_done      = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
            end
            S_EVAL: begin
                if (w_free) begin
                    n_base = w_base_r;
                    if (!r_item.drop && (w_in_win || w_in_prev)) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_ACK;
                        n_out_ack   = r_item.seq;
                        n_out_data  = '0;
                        n_out_last  = !(w_in_win && w_is_head);
                    end
                    if (!r_item.drop && w_in_win && w_is_head) begin
                        n_cnt   = '0;
                        n_state = S_DATA;
                    end else begin
                        if (!r_item.drop && w_in_win && !r_valid[w_slot]) begin
                            w_ram_we        = 1'b1;
                            n_valid[w_slot] = 1'b1;
                        end
                        w_done = 1'b1;
                    end
                end
            end
            S_DATA, S_RUN: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DATA;
                    n_out_ack   = '0;
                    n_out_data  = (r_state == S_DATA) ? r_item.data : w_rd_data;
                    n_out_last  = !w_cont;
                    n_base      = w_next_base;
                    if (r_state == S_RUN) begin
                        n_valid[r_base[SLOT_W-1:0]] = 1'b0;
                    end
                    if (w_cont) begin
                        w_ram_re = 1'b1;
                        n_cnt    = w_after;
                        n_state  = S_RUN;
                    end else begin
                        w_done = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_pop = i_head.valid && (r_state == S_IDLE || w_done);
        if (o_pop) begin
            n_item  = i_head.entry;
            n_state = S_EVAL;
        end else if (w_done) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_kind <= n_out_kind;
        r_out_ack  <= n_out_ack;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_out_kind;
    assign o_res.ack_seq        = r_out_ack;
    assign o_res.delivered_data = DATA_W'(r_out_data);
    assign o_res.last_of_run    = r_out_last;

endmodule

@@ rtl/selective_repeat_receiver.sv @@
// Selective-repeat ARQ receiver. Each transfer on i_pkt is one received
// packet; each transfer on o_res is one result: an acknowledgement or a
// payload delivered upward in order, with last_of_run set on the final result
// of a packet. Corrupted packets, numbers outside the sequence space and
// numbers outside both the receive window and the previous window give no
// result. The back end takes one packet at a time and produces one result
// per cycle while the consumer accepts them, through a single output
// register; it reads buffered payloads from a slot RAM with a registered
// read. A two-entry queue sits between the front end and the back end, so
// packets keep arriving while results are stalled. Registers are to be
// written on i_cfg only while the block is idle; the user must keep to this,
// as the block itself does not enforce it. No clearing pass is needed after
// reset.
module selective_repeat_receiver (
    input  logic i_clk,
    input  logic i_rst_n,
    srr_pkt_if.sink   i_pkt,
    srr_cfg_if.sink   i_cfg,
    srr_res_if.source o_res
);
    import srr_pkg::*;

    // Head of the classification queue and the back end's request to pop it.
    t_queue_head w_head;
    logic        w_pop;

    // The front end holds the configuration registers, derives the effective
    // window and sequence mask, flags packets that must be dropped, and
    // queues every packet. Dropped packets still travel to the back end,
    // because even a dropped packet folds the window base into the current
    // sequence space.
    srr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_cfg   (i_cfg),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // The back end owns the window base, the slot valid marks and the payload
    // buffer. It classifies each packet against the window, acknowledges,
    // stores or delivers, and walks the run of buffered in-order payloads.
    srr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

@@ rtl/srr_checker.sv @@
`include "assert_macros.svh"

module srr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_kind,
    input logic [srr_pkg::SEQ_W-1:0]  i_out_ack,
    input logic [srr_pkg::DATA_W-1:0] i_out_data,
    input logic                      i_out_last
);
    import srr_pkg::*;

    logic r_open;
    logic w_xfer;

    assign w_xfer = i_out_valid && i_out_ready;

    // Set while the results of one packet are still being transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (w_xfer) begin
            r_open <= !i_out_last;
        end
    end

    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) && $stable(i_out_ack) && $stable(i_out_data) && $stable(i_out_last))
    `ASSERT_CLKD(a_delivery_in_run, i_clk, i_rst_n, w_xfer && i_out_kind == KIND_DATA |-> r_open)
    `ASSERT_CLKD(a_ack_opens_run, i_clk, i_rst_n, w_xfer && i_out_kind == KIND_ACK |-> !r_open && i_out_data == '0)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> !i_out_valid)

endmodule

bind selective_repeat_receiver srr_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.result_kind),
    .i_out_ack   (o_res.ack_seq),
    .i_out_data  (o_res.delivered_data),
    .i_out_last  (o_res.last_of_run)
);

@@ test/tb.sv @@
module tb;
    import srr_pkg::*;

    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected result. A dropped packet gives no
    // result but still passes through the two-entry queue and the back end.
    localparam int unsigned SETTLE_CYCLES = 40;
    // Only the first mismatches are printed; the rest are just counted.
    localparam int unsigned MAX_REPORTS = 10;

    // One result as the receiver should produce it.
    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  ack;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    srr_pkt_if pkt_if ();
    srr_cfg_if cfg_if ();
    srr_res_if res_if ();

    selective_repeat_receiver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Results that the receiver owes us, oldest first.
    t_result pending_results[$];

    // Our own copy of the receiver: registers, window base and reorder buffer.
    logic [WS_W-1:0]   cfg_window;
    logic [SB_W-1:0]   cfg_seqbits;
    logic [SEQ_W-1:0]  rx_base;
    logic              buffered      [MAX_WINDOW];
    logic [DATA_W-1:0] buffered_word [MAX_WINDOW];

    int unsigned err_count;
    int unsigned idle_cycles;
    // Percentages of cycles in which the sender holds back and the result
    // consumer refuses a transfer.
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Effective number of sequence bits: zero or anything above the maximum
    // falls back to the full sixteen.
    function automatic int unsigned seq_space_bits();
        if (cfg_seqbits == 0 || cfg_seqbits > MAX_SEQ_BITS) begin
            return MAX_SEQ_BITS;
        end
        return 32'(cfg_seqbits);
    endfunction

    // Effective window: at least one, at most half the space and the buffer depth.
    function automatic int unsigned window_len();
        int unsigned space;
        int unsigned n;
        space = 32'd1 << seq_space_bits();
        n = (cfg_window == 0) ? 32'd1 : 32'(cfg_window);
        if (n > space / 2) begin
            n = space / 2;
        end
        if (n > MAX_WINDOW) begin
            n = MAX_WINDOW;
        end
        if (n == 0) begin
            n = 1;
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_result(input logic kind, input logic [SEQ_W-1:0] ack,
                                        input logic [DATA_W-1:0] data);
        t_result r;
        r.kind = kind;
        r.ack  = ack;
        r.data = data;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Work out what one accepted packet must produce and update our copy of
    // the window state. Returns the number of results expected.
    task automatic predict_packet_results(input logic [SEQ_W-1:0] seq, input logic good,
                                          input logic [DATA_W-1:0] data,
                                          output int unsigned produced);
        int unsigned mask;
        int unsigned n;
        int unsigned s;
        int unsigned b;
        int unsigned fwd_dist;
        int unsigned back;
        int unsigned slot;
        int unsigned delivered;
        mask = (32'd1 << seq_space_bits()) - 1;
        n = window_len();
        s = 32'(seq);
        // A base left over from a larger sequence space is folded back first.
        b = 32'(rx_base) & mask;
        rx_base = b[SEQ_W-1:0];
        produced = 0;
        if (good && s <= mask) begin
            fwd_dist = (s - b) & mask;
            back = (b - s) & mask;
            if (fwd_dist < n) begin
                push_result(KIND_ACK, seq, '0);
                produced++;
                slot = s % MAX_WINDOW;
                if (!buffered[slot]) begin
                    if (s == b) begin
                        // In-order packet: deliver it and everything buffered
                        // right behind it, up to one full window.
                        push_result(KIND_DATA, '0, data);
                        produced++;
                        b = (b + 1) & mask;
                        delivered = 1;
                        while (delivered < n && buffered[b % MAX_WINDOW]) begin
                            push_result(KIND_DATA, '0, buffered_word[b % MAX_WINDOW]);
                            produced++;
                            buffered[b % MAX_WINDOW] = 1'b0;
                            b = (b + 1) & mask;
                            delivered++;
                        end
                        rx_base = b[SEQ_W-1:0];
                    end else begin
                        buffered[slot] = 1'b1;
                        buffered_word[slot] = data;
                    end
                end
            end else if (back >= 1 && back <= n) begin
                // Already delivered once; the sender lost our ack, so ack again.
                push_result(KIND_ACK, seq, '0);
                produced++;
            end
        end
        if (produced > 0) begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endtask

    // Offer one packet, with random hold-off cycles first, and predict its
    // results at the edge where the transfer happens. Valid is left high so
    // that back-to-back packets need no second assignment in one time step.
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic good,
                               input logic [DATA_W-1:0] data, output int unsigned produced);
        while ($urandom_range(99) < src_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid         <= 1'b1;
        pkt_if.seq_num       <= seq;
        pkt_if.checksum_good <= good;
        pkt_if.payload       <= data;
        @(posedge i_clk);
        while (!pkt_if.ready) begin
            @(posedge i_clk);
        end
        predict_packet_results(seq, good, data, produced);
    endtask

    // Stop sending and wait until every expected result has come back, then
    // let any dropped packets still in flight drain out of the block.
    task automatic drain();
        pkt_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        if (idx == REG_WINDOW_SIZE) begin
            cfg_window = val[WS_W-1:0];
        end else if (idx == REG_SEQUENCE_BITS) begin
            cfg_seqbits = val[SB_W-1:0];
        end
    endtask

    // Registers change only once the block has gone idle.
    task automatic set_config(input logic [CFG_DAT_W-1:0] ws, input logic [CFG_DAT_W-1:0] sb);
        drain();
        write_reg(REG_WINDOW_SIZE, ws);
        write_reg(REG_SEQUENCE_BITS, sb);
        cfg_if.valid <= 1'b0;
    endtask

    // Reset settings: window of four in the full 16-bit space. Walks through
    // a corrupted packet, out-of-order storage, a duplicate of a buffered
    // packet, an in-order release of a run, re-acks from the previous window
    // and packets that fall in neither window.
    task automatic test_directed_window();
        int unsigned n_out;
        send_packet(16'd0, 1'b0, '1, n_out);                   // bad checksum
        send_packet(16'd2, 1'b1, '1, n_out);                   // stored
        send_packet(16'd2, 1'b1, rand_word(), n_out);          // already buffered
        send_packet(16'd1, 1'b1, '0, n_out);                   // stored
        send_packet(16'd0, 1'b1, 64'h0123_4567_89AB_CDEF, n_out); // releases 0..2
        send_packet(16'd0, 1'b1, rand_word(), n_out);          // previous window
        send_packet(16'hFFFF, 1'b1, rand_word(), n_out);       // wraps below base
        send_packet(16'hFFFE, 1'b1, rand_word(), n_out);       // just outside
        send_packet(16'd7, 1'b1, rand_word(), n_out);          // beyond the window
        send_packet(16'd3, 1'b1, rand_word(), n_out);          // in order again
    endtask

    // Register extremes: a two-number space with an oversized window, out of
    // range sequence bits, a zero window, and the largest window.
    task automatic test_config_extremes();
        int unsigned n_out;
        set_config(6'd63, 6'd1);
        send_packet(16'd1, 1'b1, rand_word(), n_out);          // previous window
        send_packet(16'd2, 1'b1, rand_word(), n_out);          // outside the space
        send_packet(16'd0, 1'b1, rand_word(), n_out);          // base, delivered
        set_config(6'd0, 6'd0);
        send_packet(16'd1, 1'b1, rand_word(), n_out);
        send_packet(16'd3, 1'b1, rand_word(), n_out);
        set_config(6'd32, 6'd31);
        send_packet(16'd5, 1'b1, rand_word(), n_out);
        send_packet(16'd2, 1'b1, rand_word(), n_out);
        send_packet(16'd4, 1'b1, rand_word(), n_out);
        send_packet(16'd3, 1'b1, rand_word(), n_out);          // releases 3..5
    endtask

    // Mostly well-formed traffic: shuffled bursts that fill part or all of
    // the window, so runs of every length up to a full window get released.
    // The rest is re-sent old packets, corrupted ones and random numbers.
    task automatic test_random_traffic(input int unsigned items, input logic [CFG_DAT_W-1:0] ws,
                                       input logic [CFG_DAT_W-1:0] sb);
        int unsigned counted;
        int unsigned n;
        int unsigned mask;
        int unsigned base;
        int unsigned pick;
        int unsigned k;
        int unsigned j;
        int unsigned r;
        int unsigned tmp;
        int unsigned got;
        int unsigned ofs[MAX_WINDOW];
        set_config(ws, sb);
        n = window_len();
        mask = (32'd1 << seq_space_bits()) - 1;
        counted = 0;
        while (counted < items) begin
            base = 32'(rx_base) & mask;
            pick = $urandom_range(99);
            if (pick < 60) begin
                k = $urandom_range(n, 1);
                for (j = 0; j < k; j++) begin
                    ofs[j] = j;
                end
                for (j = k - 1; j > 0; j--) begin
                    r = $urandom_range(j, 0);
                    tmp = ofs[j];
                    ofs[j] = ofs[r];
                    ofs[r] = tmp;
                end
                for (j = 0; j < k; j++) begin
                    send_packet(SEQ_W'((base + ofs[j]) & mask), 1'b1, rand_word(), got);
                    counted++;
                    if ($urandom_range(9) == 0) begin
                        send_packet(SEQ_W'((base + ofs[j]) & mask), 1'b1, rand_word(), got);
                        counted++;
                    end
                end
            end else if (pick < 75) begin
                send_packet(SEQ_W'((base - $urandom_range(n, 1)) & mask), 1'b1, rand_word(),
                            got);
                counted++;
            end else if (pick < 85) begin
                send_packet(SEQ_W'((base + $urandom_range(n - 1, 0)) & mask), 1'b0,
                            rand_word(), got);
                counted++;
            end else begin
                send_packet(SEQ_W'($urandom_range(16'hFFFF, 0)), 1'b1, rand_word(), got);
                counted++;
            end
        end
    endtask

    // Result consumer: refuses transfers at random at the current rate.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind = res_if.result_kind;
            got.ack  = res_if.ack_seq;
            got.data = res_if.delivered_data;
            got.last = res_if.last_of_run;
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result kind=%0d ack=%h data=%h last=%0d",
                             got.kind, got.ack, got.data, got.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("ERROR: expected kind=%0d ack=%h data=%h last=%0d",
                                 want.kind, want.ack, want.data, want.last);
                        $display("       actual   kind=%0d ack=%h data=%h last=%0d",
                                 got.kind, got.ack, got.data, got.last);
                    end
                end
            end
        end
    end

    // A run that stops making progress on every channel has hung.
    always @(posedge i_clk) begin
        if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        err_count    = 0;
        idle_cycles  = 0;
        cfg_window   = WINDOW_SIZE_RESET;
        cfg_seqbits  = SEQUENCE_BITS_RESET;
        rx_base      = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            buffered[i] = 1'b0;
            buffered_word[i] = '0;
        end
        // Phase one: a sender that rarely pauses, a consumer that often stalls.
        src_idle_pct = 19;
        snk_idle_pct = 80;

        i_rst_n              <= 1'b0;
        pkt_if.valid         <= 1'b0;
        pkt_if.seq_num       <= '0;
        pkt_if.checksum_good <= 1'b0;
        pkt_if.payload       <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.reg_index     <= REG_WINDOW_SIZE;
        cfg_if.wr_data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_window();
        test_config_extremes();
        test_random_traffic(70, 6'd32, 6'd16);
        test_random_traffic(60, 6'd4, 6'd3);

        // Phase two: a bursty sender, a consumer that is mostly ready.
        src_idle_pct = 80;
        snk_idle_pct = 19;
        test_random_traffic(60, 6'd20, 6'd5);
        test_random_traffic(60, 6'd63, 6'd31);

        // Phase three: full rate on both sides.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(50, 6'd1, 6'd16);
        test_random_traffic(40, 6'd8, 6'd1);
        test_random_traffic(40, 6'd7, 6'd4);

        drain();
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/srr_pkg.sv
rtl/srr_if.sv
rtl/srr_ram.sv
rtl/srr_front.sv
rtl/srr_back.sv
rtl/selective_repeat_receiver.sv
rtl/srr_checker.sv
test/tb.sv
